// ===== rtl/extent_map_read_splitter_top_assert.svh =====
// Assertion macros for the extent map read splitter top level.
// Needs clk and rst_n in scope at the point of use.
`ifndef EXTENT_MAP_READ_SPLITTER_TOP_ASSERT_SVH
`define EXTENT_MAP_READ_SPLITTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EMS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define EMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EMS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define EMS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/ems_pkg.sv =====
// Package for the extent map read splitter: constants, codes and shared types.
// No dependencies.
`timescale 1ns / 1ps

package ems_pkg;

  localparam int MAX_EXTENTS_DEF = 16;
  localparam int RESULT_LIMIT    = 49;
  localparam int OFF_W           = 48;
  localparam int AVAIL_W         = 41;

  localparam logic [31:0] HOLE_MARK   = 32'hFFFF_FFFF;
  localparam logic [9:0]  BLOCK_BYTES = 10'd512;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] CMD_ZERO = 2'd0;
  localparam logic [1:0] CMD_PART = 2'd1;
  localparam logic [1:0] CMD_BULK = 2'd2;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
  } ems_entry_t;

  typedef struct packed {
    logic             op;
    logic [OFF_W-1:0] a;
    logic [OFF_W-1:0] b;
  } ems_alu_req_t;

  typedef struct packed {
    logic [OFF_W-1:0] sum;
    logic             carry;
  } ems_alu_rsp_t;

endpackage

// ===== rtl/ems_table.sv =====
// Extent table: device start sector and size of each extent slot.
// Uses ems_pkg for the entry type.
`timescale 1ns / 1ps

module ems_table #(
  parameter int MAX_EXTENTS = ems_pkg::MAX_EXTENTS_DEF
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [3:0]        wr_idx,
  input  ems_pkg::ems_entry_t wr_data,
  input  logic [((MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1)-1:0] rd_idx,
  output ems_pkg::ems_entry_t rd_data
);
  import ems_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

  ems_entry_t entry_mem [MAX_EXTENTS];

  // Contents are undefined until a load writes the slot. The read is
  // registered, so the caller presents the slot in the cycle before it needs the data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_idx[IDX_W-1:0]] <= wr_data;
    end
    rd_data <= entry_mem[rd_idx];
  end

endmodule

// ===== rtl/ems_alu.sv =====
// Shared 48-bit add/subtract unit with carry out, used by the read sequencer.
// Uses ems_pkg for the request and response types.
`timescale 1ns / 1ps

module ems_alu (
  input  ems_pkg::ems_alu_req_t req,
  output ems_pkg::ems_alu_rsp_t rsp
);
  import ems_pkg::*;

  logic [OFF_W-1:0] b_eff;
  logic [OFF_W:0]   full;

  // For a subtract the carry out is high when there is no borrow.
  assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
  assign full  = {1'b0, req.a} + {1'b0, b_eff} + (OFF_W+1)'(req.op == ALU_SUB);
  assign rsp.sum   = full[OFF_W-1:0];
  assign rsp.carry = full[OFF_W];

endmodule

// ===== rtl/ems_seq.sv =====
// Read sequencer: walks the extents with the shared adder and emits commands
// through an output register. Uses ems_pkg; drives ems_table reads and ems_alu.
`timescale 1ns / 1ps

module ems_seq #(
  parameter int MAX_EXTENTS = ems_pkg::MAX_EXTENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [ems_pkg::OFF_W-1:0]         start_off,
  input  logic [31:0]                       start_len,
  input  logic [$clog2(MAX_EXTENTS+1)-1:0]  start_cnt,
  output logic                              busy,
  output logic [((MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1)-1:0] tbl_idx,
  input  ems_pkg::ems_entry_t               tbl_data,
  output ems_pkg::ems_alu_req_t             alu_req,
  input  ems_pkg::ems_alu_rsp_t             alu_rsp,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_cmd_kind,
  output logic [31:0]                       out_device_sector,
  output logic [23:0]                       out_sector_count,
  output logic [8:0]                        out_byte_skip,
  output logic [31:0]                       out_byte_length,
  output logic [31:0]                       out_dest_offset,
  output logic                              out_last_cmd
);
  import ems_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_END   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_POS   = 3'd3;
  localparam logic [2:0] S_CHUNK = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt, cnt_r;
  logic [5:0]         n_r;
  logic [OFF_W-1:0]   off_r, base_r, end_r;
  logic [31:0]        rem_r, dest_r, chunk_r, psec_r, start_r;
  logic [AVAIL_W-1:0] avail_r;
  logic [8:0]         skip_r;
  logic               zero_r;
  logic               out_valid_r;
  logic [1:0]         kind_r;
  logic [31:0]        sector_r, len_r, dst_r;
  logic [23:0]        count_r;
  logic [8:0]         oskip_r;
  logic               last_r;

  // Command built from the current chunk.
  logic [1:0]  c_kind;
  logic [31:0] c_sector, c_len, c_chunk_after, c_psec;
  logic [23:0] c_count;
  logic [8:0]  c_skip;
  logic [9:0]  room;
  logic        c_last, fire, past_end, hit;

  assign busy    = (state_r != S_IDLE);
  // The table read is registered, so it is addressed with the next slot.
  assign tbl_idx = idx_nxt[IDX_W-1:0];
  assign past_end = (idx_r >= cnt_r);
  assign hit     = alu_rsp.carry && (alu_rsp.sum != '0);
  assign room    = BLOCK_BYTES - {1'b0, skip_r};
  assign fire    = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    alu_req = '{op: ALU_ADD, a: '0, b: '0};
    unique case (state_r)
      S_END:   alu_req = '{op: ALU_ADD, a: base_r, b: OFF_W'({tbl_data.size, 9'd0})};
      S_CMP:   alu_req = '{op: ALU_SUB, a: end_r, b: off_r};
      S_POS:   alu_req = '{op: ALU_SUB, a: off_r, b: base_r};
      S_CHUNK: alu_req = '{op: ALU_SUB, a: OFF_W'(rem_r), b: OFF_W'(avail_r)};
      S_IDLE, S_EMIT: ;
      default: ;
    endcase
  end

  always_comb begin
    c_kind        = CMD_PART;
    c_sector      = start_r + psec_r;
    c_count       = 24'd1;
    c_skip        = 9'd0;
    c_len         = chunk_r;
    c_chunk_after = 32'd0;
    c_psec        = psec_r;
    if (zero_r) begin
      c_kind   = CMD_ZERO;
      c_sector = 32'd0;
      c_count  = 24'd0;
    end else if (skip_r != 9'd0) begin
      // Head: finish the partly covered sector first.
      c_skip        = skip_r;
      c_len         = (chunk_r < 32'(room)) ? chunk_r : 32'(room);
      c_chunk_after = chunk_r - c_len;
      c_psec        = psec_r + 32'd1;
    end else if (chunk_r[31:9] != 23'd0) begin
      c_kind        = CMD_BULK;
      c_count       = 24'(chunk_r[31:9]);
      c_len         = {chunk_r[31:9], 9'd0};
      c_chunk_after = {23'd0, chunk_r[8:0]};
      c_psec        = psec_r + 32'(chunk_r[31:9]);
    end
    c_last = ((c_chunk_after == 32'd0) && (rem_r == 32'd0)) ||
             (n_r == 6'(RESULT_LIMIT - 1));
  end

  always_comb begin
    idx_nxt = idx_r;
    if ((state_r == S_IDLE) && start) begin
      idx_nxt = '0;
    end else if ((state_r == S_CMP) && !hit) begin
      idx_nxt = idx_r + CNT_W'(1);
    end else if (fire && (c_chunk_after == 32'd0)) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_END;
      S_END:   state_nxt = past_end ? S_EMIT : S_CMP;
      S_CMP:   state_nxt = hit ? S_POS : S_END;
      S_POS:   state_nxt = S_CHUNK;
      S_CHUNK: state_nxt = S_EMIT;
      S_EMIT: begin
        if (fire) begin
          if (c_last) begin
            state_nxt = S_IDLE;
          end else if (c_chunk_after == 32'd0) begin
            state_nxt = S_END;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          off_r  <= start_off;
          base_r <= '0;
          rem_r  <= start_len;
          dest_r <= 32'd0;
          cnt_r  <= start_cnt;
          n_r    <= 6'd0;
        end
      end
      S_END: begin
        if (past_end) begin
          // Beyond the table the rest of the read is zero filled.
          zero_r  <= 1'b1;
          chunk_r <= rem_r;
          rem_r   <= 32'd0;
        end else begin
          end_r <= alu_rsp.sum;
        end
      end
      S_CMP: begin
        if (hit) begin
          avail_r <= alu_rsp.sum[AVAIL_W-1:0];
          start_r <= tbl_data.start;
          zero_r  <= (tbl_data.start == HOLE_MARK);
        end else begin
          base_r <= end_r;
        end
      end
      S_POS: begin
        psec_r <= alu_rsp.sum[AVAIL_W-1:9];
        skip_r <= alu_rsp.sum[8:0];
      end
      S_CHUNK: begin
        if (!alu_rsp.carry) begin
          chunk_r <= rem_r;
          rem_r   <= 32'd0;
        end else begin
          chunk_r <= avail_r[31:0];
          rem_r   <= alu_rsp.sum[31:0];
        end
      end
      S_EMIT: begin
        if (fire) begin
          kind_r   <= c_kind;
          sector_r <= c_sector;
          count_r  <= c_count;
          oskip_r  <= c_skip;
          len_r    <= c_len;
          dst_r    <= dest_r;
          last_r   <= c_last;
          dest_r   <= dest_r + c_len;
          n_r      <= n_r + 6'd1;
          chunk_r  <= c_chunk_after;
          psec_r   <= c_psec;
          skip_r   <= 9'd0;
          if (c_chunk_after == 32'd0) begin
            // The extent is used up, so the next chunk starts at its end.
            base_r <= end_r;
            off_r  <= end_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_cmd_kind      = kind_r;
  assign out_device_sector = sector_r;
  assign out_sector_count  = count_r;
  assign out_byte_skip     = oskip_r;
  assign out_byte_length   = len_r;
  assign out_dest_offset   = dst_r;
  assign out_last_cmd      = last_r;

endmodule

// ===== rtl/extent_map_read_splitter_top.sv =====
// Extent map read splitter top level: config register, extent table, shared
// adder and read sequencer. Uses ems_pkg, ems_table, ems_alu and ems_seq.
`timescale 1ns / 1ps
`include "extent_map_read_splitter_top_assert.svh"

// A load word writes one extent slot. A read word is split into zero-fill,
// partial-sector and bulk-sector commands, the last one flagged. A read keeps
// the input stalled while it walks the extents and emits its commands, also
// while the output stalls. The sequencer uses the single 48-bit adder for
// every offset step. A result still waiting in the output register does not
// hold off the next word.
module extent_map_read_splitter_top #(
  parameter int MAX_EXTENTS = ems_pkg::MAX_EXTENTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_req_type,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_entry_start_sector,
  input  logic [31:0] in_entry_size_blocks,
  input  logic [47:0] in_read_offset,
  input  logic [31:0] in_read_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_cmd_kind,
  output logic [31:0] out_device_sector,
  output logic [23:0] out_sector_count,
  output logic [8:0]  out_byte_skip,
  output logic [31:0] out_byte_length,
  output logic [31:0] out_dest_offset,
  output logic        out_last_cmd,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);
  import ems_pkg::*;

  localparam int IDX_W = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);

  logic [4:0]       section_count_r;
  logic [4:0]       cnt_clamp;
  logic             in_take, load_we, read_go, busy;
  logic [IDX_W-1:0] tbl_idx;
  ems_entry_t       wr_data, tbl_data;
  ems_alu_req_t     alu_req;
  ems_alu_rsp_t     alu_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_count_r <= 5'd0;
    end else if (cfg_wr_en) begin
      section_count_r <= cfg_wr_data;
    end
  end

  assign cnt_clamp = (section_count_r > 5'(MAX_EXTENTS)) ? 5'(MAX_EXTENTS) : section_count_r;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;
  // Slots at or above the table depth are dropped.
  assign load_we  = in_take && (in_req_type == REQ_LOAD) &&
                    ({1'b0, in_entry_index} < 5'(MAX_EXTENTS));
  assign read_go  = in_take && (in_req_type == REQ_READ) && (in_read_length != 32'd0);
  assign wr_data  = '{start: in_entry_start_sector, size: in_entry_size_blocks};

  ems_table #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (load_we),
    .wr_idx  (in_entry_index),
    .wr_data (wr_data),
    .rd_idx  (tbl_idx),
    .rd_data (tbl_data)
  );

  ems_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ems_seq #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (read_go),
    .start_off         (in_read_offset),
    .start_len         (in_read_length),
    .start_cnt         (cnt_clamp[CNT_W-1:0]),
    .busy              (busy),
    .tbl_idx           (tbl_idx),
    .tbl_data          (tbl_data),
    .alu_req           (alu_req),
    .alu_rsp           (alu_rsp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cmd_kind      (out_cmd_kind),
    .out_device_sector (out_device_sector),
    .out_sector_count  (out_sector_count),
    .out_byte_skip     (out_byte_skip),
    .out_byte_length   (out_byte_length),
    .out_dest_offset   (out_dest_offset),
    .out_last_cmd      (out_last_cmd)
  );

  `EMS_ASSERT_IMPLIES(a_zero_fill_clean, out_valid && (out_cmd_kind == CMD_ZERO), (out_device_sector == 32'd0) && (out_sector_count == 24'd0) && (out_byte_skip == 9'd0), "zero-fill word carries sector fields")
  `EMS_ASSERT_IMPLIES(a_len_nonzero, out_valid, out_byte_length != 32'd0, "command word with no bytes")
  `EMS_ASSERT_IMPLIES(a_part_in_sector, out_valid && (out_cmd_kind == CMD_PART), (out_sector_count == 24'd1) && ((33'(out_byte_skip) + 33'(out_byte_length)) <= 33'd512), "partial read crosses a sector")
  `EMS_ASSERT_IMPLIES(a_bulk_whole, out_valid && (out_cmd_kind == CMD_BULK), (out_byte_skip == 9'd0) && (out_byte_length == {out_sector_count[22:0], 9'd0}), "bulk length does not match sector count")
  `EMS_ASSERT_NEXT(a_no_work_idle, in_valid && !in_stall && ((in_req_type == REQ_LOAD) || (in_read_length == 32'd0)), !in_stall, "load or empty read left the sequencer busy")

endmodule
